// ----- sv/prq_pkg.sv -----
// Package: shared widths, codes and sequencer states of the process run queue.
`timescale 1ns / 1ps

package prq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int PROC_W   = 22;
    localparam int ID_W     = 5;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SCAN,
        ST_FIND
    } seq_state_t;

endpackage

// ----- sv/process_run_queue_unit.sv -----
// Top level: packed process run queue with keyed removal and free-identifier search.
`timescale 1ns / 1ps
// Sequence after an accepted word: search pass (remove only, walking from the head),
// shift pass (drop and remove; each entry behind the removed one moves up a slot), scan
// pass over the occupied entries, then free-id walk over candidates 1 up to DEPTH; done
// is registered from the walk's last step. Slowest word: remove of a full queue's head.
// One word at a time: busy drops with done, so the next word can go in at that edge.
// Reset (rst_n low, async) empties the queue; the result strobe done cannot be stalled.

module process_run_queue_unit #(
    parameter int DEPTH = prq_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic [prq_pkg::KIND_W-1:0]     kind,
    input  logic [prq_pkg::PROC_W-1:0]     proc_number,
    input  logic [prq_pkg::ID_W-1:0]       slot_id,
    output logic [prq_pkg::STATUS_W-1:0]   status,
    output logic                           head_valid,
    output logic [prq_pkg::PROC_W-1:0]     head_proc,
    output logic [prq_pkg::ID_W-1:0]       head_id,
    output logic [prq_pkg::ID_W-1:0]       entry_count,
    output logic [prq_pkg::ID_W-1:0]       free_id
);
    import prq_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Entry storage: kept packed, head at address 0. No reset on payload.
    logic [PROC_W-1:0] mem_proc [DEPTH];
    logic [ID_W-1:0]   mem_id   [DEPTH];

    logic              mem_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [PROC_W-1:0] wr_proc;
    logic [ID_W-1:0]   wr_id;
    logic [PROC_W-1:0] rd_proc_reg;
    logic [ID_W-1:0]   rd_id_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_proc[waddr] <= wr_proc;
            mem_id[waddr]   <= wr_id;
        end
        rd_proc_reg <= mem_proc[raddr];
        rd_id_reg   <= mem_id[raddr];
    end

    // Sequencer state and datapath registers
    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;   // next address to read
    logic              rdv_reg, rdv_next;             // read data in flight is live
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;     // address behind read data
    logic [CNT_W-1:0]  shift_idx_reg, shift_idx_next; // slot being refilled
    logic [DEPTH-1:0]  used_reg, used_next;           // identifier i+1 seen
    logic [CNT_W-1:0]  cand_reg, cand_next;           // free-id candidate
    logic [PROC_W-1:0] proc_reg, proc_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PROC_W-1:0] head_proc_reg, head_proc_next;
    logic [ID_W-1:0]   head_id_reg, head_id_next;
    logic [ID_W-1:0]   free_reg, free_next;
    logic              done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            scan_idx_reg  <= '0;
            rdv_reg       <= 1'b0;
            rd_addr_reg   <= '0;
            shift_idx_reg <= '0;
            used_reg      <= '0;
            cand_reg      <= '0;
            status_reg    <= STAT_OK;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            scan_idx_reg  <= scan_idx_next;
            rdv_reg       <= rdv_next;
            rd_addr_reg   <= rd_addr_next;
            shift_idx_reg <= shift_idx_next;
            used_reg      <= used_next;
            cand_reg      <= cand_next;
            status_reg    <= status_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg      <= proc_next;
        head_proc_reg <= head_proc_next;
        head_id_reg   <= head_id_next;
        free_reg      <= free_next;
    end

    // Helper values
    logic [CNT_W-1:0]  shift_nxt;
    logic [31:0]       id_w;
    logic [31:0]       id_m1;
    logic              id_in_range;
    logic [CNT_W-1:0]  cand_m1;
    logic [ADDR_W-1:0] cand_idx;
    logic [31:0]       cand_w;
    logic              enter_scan;

    assign shift_nxt   = shift_idx_reg + 1'b1;
    assign id_w        = 32'(rd_id_reg);
    assign id_m1       = id_w - 32'd1;
    assign id_in_range = (id_w >= 32'd1) && (id_w <= 32'(DEPTH));
    assign cand_m1     = cand_reg - 1'b1;
    assign cand_idx    = cand_m1[ADDR_W-1:0];
    assign cand_w      = 32'(cand_reg);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        scan_idx_next  = scan_idx_reg;
        rdv_next       = rdv_reg;
        rd_addr_next   = rd_addr_reg;
        shift_idx_next = shift_idx_reg;
        used_next      = used_reg;
        cand_next      = cand_reg;
        proc_next      = proc_reg;
        status_next    = status_reg;
        head_proc_next = head_proc_reg;
        head_id_next   = head_id_reg;
        free_next      = free_reg;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        waddr          = occ_reg[ADDR_W-1:0];
        raddr          = scan_idx_reg[ADDR_W-1:0];
        wr_proc        = proc_number;
        wr_id          = slot_id;
        enter_scan     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    proc_next   = proc_number;
                    status_next = STAT_OK;
                    case (kind)
                        KIND_APPEND:
                        begin
                            if (occ_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                            enter_scan = 1'b1;
                        end
                        KIND_DROP:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                enter_scan  = 1'b1;
                            end
                            else
                            begin
                                shift_idx_next = '0;
                                state_next     = ST_SHIFT_RD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                enter_scan  = 1'b1;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                rdv_next      = 1'b0;
                                state_next    = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            enter_scan = 1'b1;
                        end
                    endcase
                end
            end

            // walk from the head; first match wins
            ST_SEARCH:
            begin
                if (rdv_reg && (rd_proc_reg == proc_reg))
                begin
                    rdv_next       = 1'b0;
                    shift_idx_next = CNT_W'(rd_addr_reg);
                    state_next     = ST_SHIFT_RD;
                end
                else if (scan_idx_reg < occ_reg)
                begin
                    rdv_next      = 1'b1;
                    rd_addr_next  = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    if (!rdv_reg)
                    begin
                        status_next = STAT_NOT_FOUND;
                        enter_scan  = 1'b1;
                    end
                end
            end

            // close the gap: entry i+1 moves to i
            ST_SHIFT_RD:
            begin
                if (shift_nxt < occ_reg)
                begin
                    raddr      = shift_nxt[ADDR_W-1:0];
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    occ_next   = occ_reg - 1'b1;
                    enter_scan = 1'b1;
                end
            end

            ST_SHIFT_WR:
            begin
                mem_we         = 1'b1;
                waddr          = shift_idx_reg[ADDR_W-1:0];
                wr_proc        = rd_proc_reg;
                wr_id          = rd_id_reg;
                shift_idx_next = shift_nxt;
                state_next     = ST_SHIFT_RD;
            end

            // collect head and identifier usage map
            ST_SCAN:
            begin
                if (rdv_reg)
                begin
                    if (id_in_range)
                    begin
                        used_next[id_m1[ADDR_W-1:0]] = 1'b1;
                    end
                    if (rd_addr_reg == '0)
                    begin
                        head_proc_next = rd_proc_reg;
                        head_id_next   = rd_id_reg;
                    end
                end
                if (scan_idx_reg < occ_reg)
                begin
                    rdv_next      = 1'b1;
                    rd_addr_next  = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    if (!rdv_reg)
                    begin
                        cand_next  = CNT_W'(1);
                        state_next = ST_FIND;
                    end
                end
            end

            // one candidate per cycle, 1..DEPTH; stops at DEPTH so the
            // candidate never needs a value past the count width
            ST_FIND:
            begin
                if (!used_reg[cand_idx])
                begin
                    free_next  = cand_w[ID_W-1:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cand_reg == CNT_W'(DEPTH))
                begin
                    free_next  = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (enter_scan)
        begin
            scan_idx_next  = '0;
            rdv_next       = 1'b0;
            used_next      = '0;
            head_proc_next = '0;
            head_id_next   = '0;
            state_next     = ST_SCAN;
        end
    end

    logic [31:0] occ_w;
    assign occ_w = 32'(occ_reg);

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign head_valid  = (occ_reg != '0);
    assign head_proc   = head_proc_reg;
    assign head_id     = head_id_reg;
    assign entry_count = occ_w[ID_W-1:0];
    assign free_id     = free_reg;

endmodule

// ----- sv/prq_checker.sv -----
// Checker: port-level assertions for the process run queue, bound to the top level.
`timescale 1ns / 1ps

module prq_checker #(
    parameter int DEPTH = prq_pkg::DEPTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [prq_pkg::STATUS_W-1:0] status,
    input logic                         head_valid,
    input logic [prq_pkg::ID_W-1:0]     entry_count
);
    import prq_pkg::*;

    localparam logic [ID_W-1:0] FULL_CNT = ID_W'(DEPTH);

    // a word accepted always starts a sequence
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // a result only ends a busy sequence
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("done strobe outside a sequence end");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (head_valid == (entry_count != '0)))
        else $error("head_valid disagrees with entry_count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FULL)) |-> (entry_count == FULL_CNT))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_EMPTY)) |-> (entry_count == '0))
        else $error("empty status with entries queued");

endmodule

bind process_run_queue_unit prq_checker #(
    .DEPTH(DEPTH)
) u_prq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .head_valid  (head_valid),
    .entry_count (entry_count)
);

// ----- tb/tb_top.sv -----
// Testbench top: directed and random run-queue words against a built-in queue predictor.
`timescale 1ns / 1ps

module tb_top;
    import prq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    // Slowest word: a remove with search, shift, scan, free walk and done.
    localparam int DRAIN_CYCLES = 5 * QDEPTH + 20;
    localparam logic [PROC_W-1:0] PROC_MAX = '1;

    // One result word as seen on the output ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                head_valid;
        logic [PROC_W-1:0]   head_proc;
        logic [ID_W-1:0]     head_id;
        logic [ID_W-1:0]     entry_count;
        logic [ID_W-1:0]     free_id;
    } queue_view_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                done;
    logic [KIND_W-1:0]   kind;
    logic [PROC_W-1:0]   proc_number;
    logic [ID_W-1:0]     slot_id;
    logic [STATUS_W-1:0] status;
    logic                head_valid;
    logic [PROC_W-1:0]   head_proc;
    logic [ID_W-1:0]     head_id;
    logic [ID_W-1:0]     entry_count;
    logic [ID_W-1:0]     free_id;

    // Shadow copy of the run queue, head at index 0, packed in arrival order.
    logic [PROC_W-1:0] runq_proc [QDEPTH];
    logic [ID_W-1:0]   runq_ident [QDEPTH];
    int                runq_len = 0;

    // Views predicted for accepted words, oldest first.
    queue_view_t expected_views[$];
    int          err_count = 0;
    int          idle_pct  = 0;   // chance in percent that the sender idles a cycle

    process_run_queue_unit #(
        .DEPTH(QDEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .kind       (kind),
        .proc_number(proc_number),
        .slot_id    (slot_id),
        .status     (status),
        .head_valid (head_valid),
        .head_proc  (head_proc),
        .head_id    (head_id),
        .entry_count(entry_count),
        .free_id    (free_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Smallest identifier in 1..DEPTH not held by a queued entry, 0 when all are taken.
    // Walks downward so the last hit is the smallest.
    function automatic logic [ID_W-1:0] lowest_free_id();
        logic [ID_W-1:0] found;
        bit              taken;
        found = '0;
        for (int c = QDEPTH; c >= 1; c--)
        begin
            taken = 1'b0;
            for (int i = 0; i < runq_len; i++)
                if (runq_ident[i] == c)
                    taken = 1'b1;
            if (!taken)
                found = ID_W'(c);
        end
        return found;
    endfunction

    // Applies one accepted word to the shadow queue and returns the view it should produce.
    function automatic queue_view_t apply_word(input logic [KIND_W-1:0] k,
                                               input logic [PROC_W-1:0] p,
                                               input logic [ID_W-1:0]   id);
        queue_view_t v;
        int          pos;
        v.status = STAT_OK;
        pos = -1;
        case (k)
            KIND_APPEND:
                if (runq_len >= QDEPTH)
                    v.status = STAT_FULL;
                else
                begin
                    runq_proc[runq_len]  = p;
                    runq_ident[runq_len] = id;
                    runq_len++;
                end
            KIND_DROP:
                if (runq_len == 0)
                    v.status = STAT_EMPTY;
                else
                    pos = 0;
            KIND_REMOVE:
                if (runq_len == 0)
                    v.status = STAT_EMPTY;
                else
                begin
                    // first match from the head wins when numbers repeat
                    for (int i = 0; i < runq_len; i++)
                        if (pos < 0 && runq_proc[i] == p)
                            pos = i;
                    if (pos < 0)
                        v.status = STAT_NOT_FOUND;
                end
            default:
                ;
        endcase
        if (pos >= 0)
        begin
            for (int i = pos; i < runq_len - 1; i++)
            begin
                runq_proc[i]  = runq_proc[i + 1];
                runq_ident[i] = runq_ident[i + 1];
            end
            runq_len--;
        end
        v.head_valid  = (runq_len > 0);
        v.head_proc   = (runq_len > 0) ? runq_proc[0] : '0;
        v.head_id     = (runq_len > 0) ? runq_ident[0] : '0;
        v.entry_count = ID_W'(runq_len);
        v.free_id     = lowest_free_id();
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Sends one word: random idle cycles first (start low, noise on the fields),
    // then start stays high until an edge sees busy low. Start is left high so the
    // next word can follow without a gap; the caller lowers it at the end.
    task automatic send_word(input logic [KIND_W-1:0] k,
                             input logic [PROC_W-1:0] p,
                             input logic [ID_W-1:0]   id);
        while ($urandom_range(99) < idle_pct)
        begin
            start       <= 1'b0;
            kind        <= KIND_W'($urandom);
            proc_number <= PROC_W'($urandom);
            slot_id     <= ID_W'($urandom);
            @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= k;
        proc_number <= p;
        slot_id     <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_views.push_back(apply_word(k, p, id));
    endtask

    // Result checker: done marks a one-cycle result that cannot be held off,
    // so it is taken at the edge that ends that cycle and compared at once.
    always @(posedge clk)
    begin : check_results
        queue_view_t want;
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = expected_views.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (head_valid !== want.head_valid)
                    report_mismatch("head_valid", head_valid, want.head_valid);
                if (head_proc !== want.head_proc)
                    report_mismatch("head_proc", head_proc, want.head_proc);
                if (head_id !== want.head_id)
                    report_mismatch("head_id", head_id, want.head_id);
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", entry_count, want.entry_count);
                if (free_id !== want.free_id)
                    report_mismatch("free_id", free_id, want.free_id);
            end
        end
    end

    // Drop, remove and query on an empty queue; extreme field values.
    task automatic test_empty_queue();
        send_word(KIND_DROP, PROC_MAX, ID_W'(16));
        send_word(KIND_REMOVE, PROC_MAX, '0);
        send_word(KIND_QUERY, '0, '0);
    endtask

    // Fill to DEPTH with identifiers DEPTH..1 so no free identifier is left,
    // with two entries sharing a number; then an append that must be refused.
    task automatic test_fill_to_full();
        logic [PROC_W-1:0] p;
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (i == 0)
                p = '0;
            else if (i == QDEPTH - 1)
                p = PROC_MAX;
            else if (i == 5 || i == 10)
                p = 22'h2AAAAA;
            else
                p = PROC_W'(i * 977);
            send_word(KIND_APPEND, p, ID_W'(QDEPTH - i));
        end
        send_word(KIND_APPEND, 22'h155555, '0);
        send_word(KIND_QUERY, PROC_MAX, ID_W'(16));
    endtask

    // Missing number, duplicate numbers (nearest the head goes first), tail and head.
    task automatic test_keyed_removal();
        send_word(KIND_REMOVE, 22'h123456, '0);
        send_word(KIND_REMOVE, 22'h2AAAAA, '0);
        send_word(KIND_REMOVE, PROC_MAX, '0);
        send_word(KIND_DROP, '0, '0);
        send_word(KIND_REMOVE, 22'h2AAAAA, '0);
    endtask

    // Process numbers: a small pool for duplicates, values near the top, or anything.
    function automatic logic [PROC_W-1:0] random_proc();
        case ($urandom_range(3))
            0:       return PROC_W'($urandom_range(7));
            1:       return PROC_MAX - PROC_W'($urandom_range(3));
            default: return PROC_W'($urandom);
        endcase
    endfunction

    // Random traffic in blocks of 40 words that lean toward filling or draining,
    // so the queue keeps reaching both full and empty. Removals mostly name a
    // queued number; appends often take the next free identifier.
    task automatic test_random_traffic(input int n_words, input int pct);
        logic [KIND_W-1:0] k;
        logic [PROC_W-1:0] p;
        logic [ID_W-1:0]   id;
        int                fill_bias;
        int                r;
        idle_pct = pct;
        for (int j = 0; j < n_words; j++)
        begin
            fill_bias = ((j / 40) % 2 == 0) ? 65 : 20;
            r  = $urandom_range(99);
            p  = random_proc();
            id = ID_W'($urandom_range(16));
            if (r < fill_bias)
            begin
                k = KIND_APPEND;
                if ($urandom_range(1) == 0)
                    id = lowest_free_id();
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 25)
                    k = KIND_DROP;
                else if (r < 88)
                begin
                    k = KIND_REMOVE;
                    if (runq_len > 0 && $urandom_range(99) < 80)
                        p = runq_proc[$urandom_range(runq_len - 1)];
                end
                else
                    k = KIND_QUERY;
            end
            send_word(k, p, id);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= KIND_QUERY;
        proc_number <= '0;
        slot_id     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_to_full();
        test_keyed_removal();
        // sender idle mix: light, then heavy, then back to back
        test_random_traffic(420, 21);
        test_random_traffic(420, 83);
        test_random_traffic(410, 0);
        start <= 1'b0;

        while (expected_views.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/prq_pkg.sv
sv/process_run_queue_unit.sv
sv/prq_checker.sv
tb/tb_top.sv
